FILE: rtl/core/sobs_pkg.sv
// Shared types for the set-of-bounded-stacks block: operation and status codes
// and the request bundle passed from the controller to the top level.
// No dependencies.
package sobs_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_POP_AT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  localparam logic [4:0] LIMIT_RESET = 5'd10;

  // Store access and result info for one request.
  typedef struct packed {
    logic        wr;
    logic        rd;
    status_t     status;
    logic [2:0]  active_after;
  } sobs_req_t;

endpackage

FILE: rtl/core/sobs_ctrl.sv
// Bookkeeping for the set of stacks: fill counts, active stack, stacks in use
// and the limit register. Produces the store address and request info.
// Depends on sobs_pkg.
module sobs_ctrl #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16,
  parameter int AW          = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  sobs_pkg::op_t         in_operation,
  input  logic [2:0]            in_stack_index,
  input  logic                  cfg_wr_en,
  input  logic [4:0]            cfg_wr_data,
  output sobs_pkg::sobs_req_t   req,
  output logic [AW-1:0]         addr
);

  localparam int SW = $clog2(NUM_STACKS);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int UW = $clog2(NUM_STACKS + 1);
  localparam int LW = (FW > 5) ? FW : 5;
  localparam int IW = (UW > 3) ? UW : 3;

  logic [4:0]    limit_r;
  logic [FW-1:0] fill_r [NUM_STACKS];
  logic [SW-1:0] act_r, act_nxt;
  logic [FW-1:0] fill_act_r, fill_act_nxt;
  logic [FW-1:0] fill_below_r, fill_below_nxt;
  logic [UW-1:0] in_use_r, in_use_nxt;

  logic [LW-1:0] lim;
  logic          is_full;
  logic          is_last;
  logic [SW-1:0] act_m1, act_m2, idx_s, rd_sel;
  logic [FW-1:0] fill_rd;
  logic          idx_ok;
  logic          arr_we;
  logic [SW-1:0] arr_idx;
  logic [FW-1:0] arr_val;
  logic [SW-1:0] sel_s;
  logic [FW-1:0] sel_f;

  always_comb begin
    if (limit_r == 5'd0) begin
      lim = LW'(1);
    end else if (LW'(limit_r) > LW'(STACK_DEPTH)) begin
      lim = LW'(STACK_DEPTH);
    end else begin
      lim = LW'(limit_r);
    end
  end

  assign is_full = LW'(fill_act_r) >= lim;
  assign is_last = act_r == SW'(NUM_STACKS - 1);
  assign act_m1  = act_r - SW'(1);
  assign act_m2  = act_r - SW'(2);
  assign idx_s   = SW'(in_stack_index);
  assign rd_sel  = (in_operation == sobs_pkg::OP_POP_AT) ? idx_s : act_m2;
  assign fill_rd = fill_r[rd_sel];
  assign idx_ok  = (IW'(in_stack_index) < IW'(in_use_r)) &&
                   (IW'(in_stack_index) < IW'(NUM_STACKS)) && (fill_rd != '0);

  // Stacks above the active one are always empty, so a push that moves up
  // starts the new stack at slot zero.
  always_comb begin
    act_nxt        = act_r;
    fill_act_nxt   = fill_act_r;
    fill_below_nxt = fill_below_r;
    in_use_nxt     = in_use_r;
    arr_we         = 1'b0;
    arr_idx        = act_r;
    arr_val        = fill_act_r;
    sel_s          = act_r;
    sel_f          = fill_act_r;
    req.wr         = 1'b0;
    req.rd         = 1'b0;
    req.status     = sobs_pkg::ST_OK;
    case (in_operation)
      sobs_pkg::OP_PUSH: begin
        if (is_full && is_last) begin
          req.status = sobs_pkg::ST_OVERFLOW;
        end else if (is_full) begin
          act_nxt        = act_r + SW'(1);
          fill_act_nxt   = FW'(1);
          fill_below_nxt = fill_act_r;
          if (in_use_r < UW'(act_r) + UW'(2)) begin
            in_use_nxt = UW'(act_r) + UW'(2);
          end
          sel_s   = act_r + SW'(1);
          sel_f   = '0;
          arr_we  = 1'b1;
          arr_idx = act_r + SW'(1);
          arr_val = FW'(1);
          req.wr  = 1'b1;
        end else begin
          fill_act_nxt = fill_act_r + FW'(1);
          arr_we       = 1'b1;
          arr_val      = fill_act_r + FW'(1);
          req.wr       = 1'b1;
        end
      end
      sobs_pkg::OP_POP, sobs_pkg::OP_PEEK: begin
        if (fill_act_r != '0) begin
          sel_f  = fill_act_r - FW'(1);
          req.rd = 1'b1;
          if (in_operation == sobs_pkg::OP_POP) begin
            fill_act_nxt = fill_act_r - FW'(1);
            arr_we       = 1'b1;
            arr_val      = fill_act_r - FW'(1);
          end
        end else if (act_r != '0 && fill_below_r != '0) begin
          sel_s  = act_m1;
          sel_f  = fill_below_r - FW'(1);
          req.rd = 1'b1;
          if (in_operation == sobs_pkg::OP_POP) begin
            act_nxt        = act_m1;
            fill_act_nxt   = fill_below_r - FW'(1);
            fill_below_nxt = (act_r >= SW'(2)) ? fill_rd : '0;
            arr_we         = 1'b1;
            arr_idx        = act_m1;
            arr_val        = fill_below_r - FW'(1);
          end
        end else begin
          req.status = sobs_pkg::ST_EMPTY;
        end
      end
      sobs_pkg::OP_POP_AT: begin
        if (!idx_ok) begin
          req.status = sobs_pkg::ST_BAD_INDEX;
        end else begin
          sel_s   = idx_s;
          sel_f   = fill_rd - FW'(1);
          req.rd  = 1'b1;
          arr_we  = 1'b1;
          arr_idx = idx_s;
          arr_val = fill_rd - FW'(1);
          if (idx_s == act_r) begin
            fill_act_nxt = fill_rd - FW'(1);
          end
          if (act_r != '0 && idx_s == act_m1) begin
            fill_below_nxt = fill_rd - FW'(1);
          end
        end
      end
      default: begin
        req.status = sobs_pkg::ST_OK;
      end
    endcase
    req.wr           = req.wr & in_valid;
    req.rd           = req.rd & in_valid;
    req.active_after = 3'(act_nxt);
  end

  assign addr = AW'(sel_s) * AW'(STACK_DEPTH) + AW'(sel_f);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= sobs_pkg::LIMIT_RESET;
      act_r        <= '0;
      fill_act_r   <= '0;
      fill_below_r <= '0;
      in_use_r     <= UW'(1);
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (in_valid) begin
        act_r        <= act_nxt;
        fill_act_r   <= fill_act_nxt;
        fill_below_r <= fill_below_nxt;
        in_use_r     <= in_use_nxt;
        if (arr_we) begin
          fill_r[arr_idx] <= arr_val;
        end
      end
    end
  end

  a_active_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    UW'(act_r) < in_use_r)
    else $error("active stack is not below the number of stacks in use");

  a_fill_act_cache: assert property (@(posedge clk) disable iff (!rst_n)
    fill_act_r == fill_r[act_r])
    else $error("cached fill of the active stack disagrees with the fill table");

  a_fill_below_cache: assert property (@(posedge clk) disable iff (!rst_n)
    act_r != '0 |-> fill_below_r == fill_r[act_m1])
    else $error("cached fill of the stack below disagrees with the fill table");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(fill_act_r) <= FW'(STACK_DEPTH))
    else $error("active stack fill exceeds the stack depth");

  a_overflow_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && req.status == sobs_pkg::ST_OVERFLOW |-> is_last && !req.wr)
    else $error("overflow reported while a further stack was available");

endmodule

FILE: rtl/core/set_of_bounded_stacks.sv
// Set of bounded stacks: several fixed-depth stacks that behave as one stack.
// The result strobe rises in the cycle after a request is taken.
// Throughput: one request every cycle; busy never rises and the receiver cannot stall.
// Reset: all fills clear, stack 0 is active and alone in use, the limit becomes 10.
// The value store is not cleared; only slots written by a push are ever read.
module set_of_bounded_stacks #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_push_value,
  input  logic [2:0]         in_stack_index,
  output logic               out_strobe,
  output logic signed [31:0] out_read_value,
  output logic [1:0]         out_status,
  output logic [2:0]         out_active_after,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data
);

  // Stack s, slot k sits at store address s*STACK_DEPTH + k.
  localparam int ENTRIES = NUM_STACKS * STACK_DEPTH;
  localparam int AW      = $clog2(ENTRIES);

  logic                          accept;
  sobs_pkg::sobs_req_t           req;
  logic [AW-1:0]                 addr;
  logic [VALUE_WIDTH-1:0]        store_mem [ENTRIES];
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic                          strobe_r;
  logic                          rd_ok_r;
  sobs_pkg::status_t             status_r;
  logic [2:0]                    active_r;

  // Every cycle can take a request: the whole decision fits between the
  // input and the result register.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // The controller keeps fill counts and the active stack, and picks the one
  // store slot this request touches.
  sobs_ctrl #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (accept),
    .in_operation   (sobs_pkg::op_t'(in_operation)),
    .in_stack_index (in_stack_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .req            (req),
    .addr           (addr)
  );

  // Single-port value store. A push writes and a pop or peek reads, never
  // both in one cycle. A read in the cycle after a push to the same slot
  // sees the new value because the write has already landed.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      store_mem[addr] <= VALUE_WIDTH'(in_push_value);
    end
    if (req.rd) begin
      rd_data_r <= store_mem[addr];
    end
  end

  // Result register: status and active stack are captured with the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      rd_ok_r  <= 1'b0;
    end else begin
      strobe_r <= accept;
      rd_ok_r  <= req.rd;
    end
    if (accept) begin
      status_r <= req.status;
      active_r <= req.active_after;
    end
  end

  // Stored values are sign-extended from the value width into the 32-bit field;
  // anything other than a successful pop or peek reports zero.
  assign out_strobe       = strobe_r;
  assign out_read_value   = rd_ok_r ? 32'(rd_data_r) : '0;
  assign out_status       = status_r;
  assign out_active_after = active_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("request taken without a result in the next cycle");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != sobs_pkg::ST_OK |-> out_read_value == '0)
    else $error("failed request reported a nonzero value");

  a_store_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.wr && req.rd))
    else $error("store read and write requested in the same cycle");

endmodule
